// ----- hw/rtl/sus_pkg.sv -----
`default_nettype none
package sus_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  typedef enum logic [1:0] {
    KIND_SEARCH = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOCHG = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef struct packed {
    logic ins;
    logic del;
    val_t key;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sus_if.sv -----
`default_nettype none
interface sus_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic signed [31:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface sus_out_if;
  logic       valid;
  logic       ready;
  logic       was_present;
  logic [1:0] status;
  logic [4:0] entry_count;

  modport source (output valid, was_present, status, entry_count, input ready);
  modport sink   (input valid, was_present, status, entry_count, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sus_cell.sv -----
`default_nettype none
module sus_cell (
  input  wire logic                clk,
  input  wire sus_pkg::cell_ctrl_t ctrl,
  input  wire logic                vld,
  input  wire logic                left_lt,
  input  wire sus_pkg::val_t       left_val,
  input  wire sus_pkg::val_t       right_val,
  output logic                     lt,
  output logic                     eq,
  output sus_pkg::val_t            val
);
  import sus_pkg::*;

  val_t val_r;
  val_t val_nxt;

  assign val = val_r;
  assign lt  = vld && (val_r < ctrl.key);
  assign eq  = vld && (val_r == ctrl.key);

  // insert: below-key cells hold, first other takes key, rest shift right
  // delete: cells from the match onwards pull from the right
  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins) begin
      if (!lt) begin
        val_nxt = left_lt ? ctrl.key : left_val;
      end
    end else if (ctrl.del) begin
      if (!lt) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sorted_unique_set_engine.sv -----
// channel | dir | handshake     | payload
// in_ch   | in  | valid/ready   | kind[1:0], value[31:0] signed
// out_ch  | out | valid/ready   | was_present, status[1:0], entry_count[4:0]
//
// One operation per cycle unless the output stalls: every cell compares in
// parallel, the row shifts in the same edge, and the result is registered.
// Synchronous active-low reset empties the set; cell values are not reset.
// A single output register holds the result; a new beat is taken whenever
// that register is empty or being drained in the same cycle.
`default_nettype none
module sorted_unique_set_engine (
  input  wire logic clk,
  input  wire logic rst_n,
  sus_in_if.sink    in_ch,
  sus_out_if.source out_ch
);
  import sus_pkg::*;

  cnt_t       cnt_r;
  cnt_t       cnt_nxt;
  logic       out_vld_r;
  logic       present_r;
  logic [1:0] status_r;
  logic [4:0] count_r;

  logic       acc;
  logic       present;
  logic       full;
  logic [1:0] status;
  cell_ctrl_t ctrl;

  logic [CAPACITY-1:0] lt_v;
  logic [CAPACITY-1:0] eq_v;
  val_t                val_v [CAPACITY];

  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign present     = |eq_v;
  assign full        = (cnt_r == CNT_W'(CAPACITY));

  always_comb begin
    ctrl.key = in_ch.value;
    ctrl.ins = 1'b0;
    ctrl.del = 1'b0;
    cnt_nxt  = cnt_r;
    status   = ST_DONE;
    case (kind_t'(in_ch.kind))
      KIND_INSERT: begin
        if (present) begin
          status = ST_NOCHG;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.ins = acc;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      KIND_DELETE: begin
        if (present) begin
          ctrl.del = acc;
          cnt_nxt  = cnt_r - 1'b1;
        end else begin
          status = ST_NOCHG;
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic vld;
    logic lft_lt;
    val_t lft_val;
    val_t rgt_val;

    assign vld = (CNT_W'(i) < cnt_r);
    if (i == 0) begin : g_first
      assign lft_lt  = 1'b1;
      assign lft_val = val_v[i];
    end else begin : g_mid
      assign lft_lt  = lt_v[i-1];
      assign lft_val = val_v[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rgt_val = val_v[i];
    end else begin : g_nrm
      assign rgt_val = val_v[i+1];
    end

    sus_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .vld       (vld),
      .left_lt   (lft_lt),
      .left_val  (lft_val),
      .right_val (rgt_val),
      .lt        (lt_v[i]),
      .eq        (eq_v[i]),
      .val       (val_v[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (acc) begin
        cnt_r     <= cnt_nxt;
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      present_r <= present;
      status_r  <= status;
      count_r   <= 5'(cnt_nxt);
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.was_present = present_r;
  assign out_ch.status      = status_r;
  assign out_ch.entry_count = count_r;

endmodule
`default_nettype wire

// ----- dv/sorted_set_checker.sv -----
`timescale 1ns / 1ps
module sorted_set_checker (
  input  logic clk,
  input  logic rst_n,
  sus_in_if    in_mon,
  sus_out_if   out_mon,
  output int   fail_count,
  output int   outstanding
);
  import sus_pkg::*;

  typedef struct packed {
    logic       was_present;
    logic [1:0] status;
    logic [4:0] entry_count;
  } set_result_t;

  val_t        set_vals [CAPACITY];
  int          set_size;
  set_result_t expected_q [$];

  // Updates the shadow set and returns the result the block should give.
  function automatic set_result_t apply_set_op(input kind_t op, input val_t v);
    int          below;
    logic        hit;
    set_result_t r;
    below = 0;
    hit   = 1'b0;
    for (int i = 0; i < set_size; i++) begin
      if (set_vals[i] < v) begin
        below++;
      end else if (set_vals[i] == v) begin
        hit = 1'b1;
      end
    end
    r.status = ST_DONE;
    case (op)
      KIND_INSERT: begin
        if (hit) begin
          r.status = ST_NOCHG;
        end else if (set_size >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = set_size; i > below; i--) set_vals[i] = set_vals[i-1];
          set_vals[below] = v;
          set_size++;
        end
      end
      KIND_DELETE: begin
        if (hit) begin
          for (int i = below; i + 1 < set_size; i++) set_vals[i] = set_vals[i+1];
          set_size--;
        end else begin
          r.status = ST_NOCHG;
        end
      end
      default: r.status = ST_DONE;
    endcase
    r.was_present = hit;
    r.entry_count = set_size[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    set_result_t want;
    if (!rst_n) begin
      set_size   = 0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no operation outstanding");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_mon.was_present !== want.was_present) begin
            $error("was_present: expected %0d, got %0d", want.was_present,
                   out_mon.was_present);
            fail_count++;
          end
          if (out_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_mon.status);
            fail_count++;
          end
          if (out_mon.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_mon.entry_count);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(apply_set_op(kind_t'(in_mon.kind), in_mon.value));
      end
    end
    outstanding = expected_q.size();
  end

endmodule

// ----- dv/sorted_unique_set_engine_test.sv -----
`timescale 1ns / 1ps
module sorted_unique_set_engine_test;
  import sus_pkg::*;

  localparam int OP_COUNT  = 750;
  localparam int CALM_TAIL = 100;

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   gap_pct;
  int   stall_pct;
  int   stall_left;

  sus_in_if  in_ch ();
  sus_out_if out_ch ();

  sorted_unique_set_engine i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sorted_set_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // result side back-pressure, in random bursts
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (rst_n && $urandom_range(99) < stall_pct) begin
        out_ch.ready = 1'b0;
        stall_left   = $urandom_range(2);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic send_op(input kind_t k, input val_t v);
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.kind  = k;
    in_ch.value = v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk);
    in_ch.valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (outstanding == 0);
  endtask

  function automatic int idle_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  function automatic kind_t pick_kind(input int mode);
    int r;
    r = $urandom_range(99);
    if (r < 5) return KIND_SPARE;
    if (r < 20) return KIND_SEARCH;
    case (mode)
      MODE_FILL:  return (r < 85) ? KIND_INSERT : KIND_DELETE;
      MODE_DRAIN: return (r < 85) ? KIND_DELETE : KIND_INSERT;
      default:    return (r < 60) ? KIND_INSERT : KIND_DELETE;
    endcase
  endfunction

  // narrow pool so hits, duplicates and a full set are common
  function automatic val_t pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 75) return val_t'(int'($urandom_range(47)) - 24);
    if (r < 85) begin
      case ($urandom_range(3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return val_t'($urandom);
  endfunction

  initial begin
    int mode;
    int run_len;
    int sent;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind  = KIND_SEARCH;
    in_ch.value = '0;
    gap_pct     = 0;
    stall_pct   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    stall_pct = 20;
    send_op(KIND_SEARCH, 32'sh0);
    send_op(KIND_DELETE, 32'sd5);
    send_op(KIND_INSERT, 32'sh8000_0000);
    send_op(KIND_INSERT, 32'sh7fff_ffff);
    send_op(KIND_INSERT, 32'sh0);
    send_op(KIND_INSERT, -32'sd1);
    send_op(KIND_INSERT, 32'sd1);
    send_op(KIND_INSERT, 32'sh7fff_ffff);
    send_op(KIND_SEARCH, 32'sh8000_0000);
    send_op(KIND_SPARE,  32'sh8000_0000);
    send_op(KIND_SPARE,  32'sd77);
    send_op(KIND_DELETE, 32'sh0);
    send_op(KIND_DELETE, 32'sh8000_0000);
    send_op(KIND_DELETE, 32'sh7fff_ffff);
    send_op(KIND_DELETE, 32'sh0);
    send_op(KIND_SEARCH, 32'sh0);
    send_op(KIND_INSERT, 32'sh5555_5555);
    send_op(KIND_INSERT, 32'shaaaa_aaaa);
    send_op(KIND_SEARCH, 32'sh5555_5555);
    wait_drained();

    mode    = MODE_FILL;
    run_len = 60;
    sent    = 0;
    while (sent < OP_COUNT) begin
      if (run_len == 0) begin
        mode      = $urandom_range(MODE_MIXED);
        run_len   = $urandom_range(20, 60);
        gap_pct   = idle_pct();
        stall_pct = idle_pct();
      end
      if (sent == OP_COUNT / 2) wait_drained();
      if (sent >= OP_COUNT - CALM_TAIL) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      if ($urandom_range(99) < gap_pct) hold_off($urandom_range(1, 3));
      send_op(pick_kind(mode), pick_value());
      sent++;
      run_len--;
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sus_pkg.sv
hw/rtl/sus_if.sv
hw/rtl/sus_cell.sv
hw/rtl/sorted_unique_set_engine.sv
dv/sorted_set_checker.sv
dv/sorted_unique_set_engine_test.sv
